FILE: hdl/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared sizes, register indexes, control types and helpers.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 16;
    localparam int ACC_WIDTH   = 40;
    localparam int DIM_WIDTH   = 4;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
    localparam int IDX_WIDTH   = $clog2(MAX_DIM);
    localparam int CNT_WIDTH   = $clog2(2 * STORE_DEPTH);
    localparam int SIZE_WIDTH  = CNT_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COLS_B = 2'd3;

    localparam logic [DIM_WIDTH-1:0] DIM_MAX = DIM_WIDTH'(MAX_DIM);
    localparam logic [DIM_WIDTH-1:0] DIM_ONE = DIM_WIDTH'(1);

    // Control that travels down the multiply-accumulate pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mm_mac_ctl_t;

    // Zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v);
        logic [DIM_WIDTH-1:0] r;
        begin
            if (v == '0) begin
                r = DIM_ONE;
            end else if (v > DIM_MAX) begin
                r = DIM_MAX;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

FILE: hdl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// Matrix multiply
// Loads A then B one element per item, then sends A*B in row-major order.
// ----------------------------------------------------------------------------
// The block takes one element per cycle while loading: rows_a*cols_a elements
// of A, then rows_b*cols_b elements of B, both row-major, signed Q8.8. The
// item that completes B starts the computation and s_axis_tready stays low
// until the run is sent. With unequal inner dimensions a single item with
// tuser set and zero data is sent. Otherwise each product element is summed
// on the one multiply-accumulate unit (one read of each store per term,
// three pipeline stages, then a hand-over of the sum to the output
// register), and the next sum is computed while the previous one waits on
// m_axis. Sizes of 0 act as 1, sizes above 8 act as 8. tlast marks the
// final item of a run.
// ----------------------------------------------------------------------------
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,   // [15:0] element_value
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [39:0]              m_axis_tdata,   // [39:0] product_value
    output logic                     m_axis_tuser,   // [0] status
    output logic                     m_axis_tlast,   // last_result
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [DIM_WIDTH-1:0]     cfg_wdata
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_ERR   = 5'b10000
    } mm_state_t;

    mm_state_t state_reg, state_next;

    logic [DIM_WIDTH-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [DIM_WIDTH-1:0] ra, ca, rb, cb;
    logic [SIZE_WIDTH-1:0] na, nb, total, pos_ext, pos_inc;
    logic [SIZE_WIDTH-1:0] b_off;

    logic [CNT_WIDTH-1:0]  pos_reg, pos_next;
    logic [IDX_WIDTH-1:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [ADDR_WIDTH-1:0] a_row_reg, a_row_next, a_ptr_reg, a_ptr_next;
    logic [ADDR_WIDTH-1:0] b_ptr_reg, b_ptr_next;

    logic                  s_accept, last_elem, k_last, r_last, c_last;
    logic                  a_we, b_we;
    logic [DATA_WIDTH-1:0] a_rdata, b_rdata;
    mm_mac_ctl_t           issue;
    logic                  mac_done;
    logic signed [ACC_WIDTH-1:0] mac_acc;

    logic                 m_valid_reg, m_valid_next;
    logic [ACC_WIDTH-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;
    logic                 out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= DIM_ONE;
            cols_a_reg <= DIM_ONE;
            rows_b_reg <= DIM_ONE;
            cols_b_reg <= DIM_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS_A: rows_a_reg <= cfg_wdata;
                REG_COLS_A: cols_a_reg <= cfg_wdata;
                REG_ROWS_B: rows_b_reg <= cfg_wdata;
                REG_COLS_B: cols_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ra = clamp_dim(rows_a_reg);
    assign ca = clamp_dim(cols_a_reg);
    assign rb = clamp_dim(rows_b_reg);
    assign cb = clamp_dim(cols_b_reg);

    assign na      = SIZE_WIDTH'(ra) * SIZE_WIDTH'(ca);
    assign nb      = SIZE_WIDTH'(rb) * SIZE_WIDTH'(cb);
    assign total   = na + nb;
    assign pos_ext = SIZE_WIDTH'(pos_reg);
    assign pos_inc = pos_ext + SIZE_WIDTH'(1);
    assign b_off   = pos_ext - na;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign last_elem     = (pos_inc >= total);

    // Store only positions that fall inside A or B
    assign a_we = s_accept & (pos_ext < na);
    assign b_we = s_accept & (pos_ext >= na) & (pos_ext < total);

    assign k_last = ({1'b0, k_reg} + DIM_ONE == ca);
    assign r_last = ({1'b0, r_reg} + DIM_ONE == ra);
    assign c_last = ({1'b0, c_reg} + DIM_ONE == cb);

    assign out_free = ~m_valid_reg | m_axis_tready;

    always_comb begin
        issue.valid = (state_reg == ST_MAC);
        issue.first = (k_reg == '0);
        issue.last  = k_last;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        a_row_next   = a_row_reg;
        a_ptr_next   = a_ptr_reg;
        b_ptr_next   = b_ptr_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (last_elem) begin
                        pos_next   = '0;
                        r_next     = '0;
                        c_next     = '0;
                        k_next     = '0;
                        a_row_next = '0;
                        a_ptr_next = '0;
                        b_ptr_next = '0;
                        state_next = (ca != rb) ? ST_ERR : ST_MAC;
                    end else begin
                        pos_next = CNT_WIDTH'(pos_inc);
                    end
                end
            end
            ST_MAC: begin
                if (k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next     = k_reg + IDX_WIDTH'(1);
                    a_ptr_next = a_ptr_reg + ADDR_WIDTH'(1);
                    b_ptr_next = b_ptr_reg + ADDR_WIDTH'(cb);
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mac_acc;
                    m_user_next  = 1'b0;
                    m_last_next  = r_last & c_last;
                    k_next       = '0;
                    if (r_last & c_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_MAC;
                        if (c_last) begin
                            c_next     = '0;
                            r_next     = r_reg + IDX_WIDTH'(1);
                            a_row_next = a_row_reg + ADDR_WIDTH'(ca);
                            a_ptr_next = a_row_reg + ADDR_WIDTH'(ca);
                            b_ptr_next = '0;
                        end else begin
                            c_next     = c_reg + IDX_WIDTH'(1);
                            a_ptr_next = a_row_reg;
                            b_ptr_next = ADDR_WIDTH'(c_reg) + ADDR_WIDTH'(1);
                        end
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = 1'b1;
                    m_last_next  = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        a_row_reg  <= a_row_next;
        a_ptr_reg  <= a_ptr_next;
        b_ptr_reg  <= b_ptr_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    mm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (pos_reg[ADDR_WIDTH-1:0]),
        .wdata (s_axis_tdata),
        .raddr (a_ptr_reg),
        .rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_off[ADDR_WIDTH-1:0]),
        .wdata (s_axis_tdata),
        .raddr (b_ptr_reg),
        .rdata (b_rdata)
    );

    mm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

FILE: hdl/mm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/mm_mac.sv
// ----------------------------------------------------------------------------
// Matrix multiply MAC unit
// Shared multiply-accumulate: aligns with RAM read, multiplies, accumulates.
// ----------------------------------------------------------------------------
module mm_mac
    import mm_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mm_mac_ctl_t                  issue,
    input  logic signed [DATA_WIDTH-1:0] a_data,
    input  logic signed [DATA_WIDTH-1:0] b_data,
    output logic                         done,
    output logic signed [ACC_WIDTH-1:0]  acc
);

    mm_mac_ctl_t ctl1_reg, ctl2_reg;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic signed [ACC_WIDTH-1:0]  prod_ext;
    logic                         done_reg;

    assign prod_ext = ACC_WIDTH'(prod_reg);

    always_comb begin
        acc_next = acc_reg;
        if (ctl2_reg.valid) begin
            acc_next = ctl2_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid & ctl2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_data * b_data;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

FILE: verif/matrix_multiply_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Streams A and B elements into the block under random sizes and handshake
// gaps, predicts every product element in the bench and checks each result
// item against the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_multiply_test;
    import mm_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 16;
    localparam int unsigned RANDOM_ITEMS = 80;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] product;
        logic                        status;
        logic                        last;
    } product_item_t;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [15:0]              s_axis_tdata  = '0;    // [15:0] element_value
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [39:0]              m_axis_tdata;          // [39:0] product_value
    logic                     m_axis_tuser;          // [0] status
    logic                     m_axis_tlast;          // last_result
    logic                     cfg_we        = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index     = REG_ROWS_A;
    logic [DIM_WIDTH-1:0]     cfg_wdata     = '0;

    // Bench copy of the block's registers and element stores
    logic [DIM_WIDTH-1:0]         dim_regs [4] = '{default: DIM_ONE};
    logic signed [DATA_WIDTH-1:0] a_elems [STORE_DEPTH];
    logic signed [DATA_WIDTH-1:0] b_elems [STORE_DEPTH];
    int unsigned                  load_pos = 0;

    logic [15:0]   outgoing_elements [$];
    product_item_t pending_products [$];
    int unsigned   elements_queued = 0;
    int unsigned   elements_taken  = 0;
    int unsigned   mismatches      = 0;
    int unsigned   cycle_count     = 0;

    int          src_mode  = 1;
    int          snk_mode  = 1;
    int unsigned src_gap   = 0;
    int unsigned snk_gap   = 0;
    logic        hold_request = 1'b0;
    logic        hold_taken   = 1'b0;
    int unsigned hold_left    = 0;

    matrix_multiply dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    function automatic int unsigned effective_dim(input logic [DIM_WIDTH-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return 32'(v);
    endfunction

    // Mode 0: no gaps, 1: occasional gaps, 2: gaps on most items
    function automatic int unsigned draw_gap(input int mode);
        if (mode == 0) begin
            return 0;
        end else if (mode == 1) begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [DIM_WIDTH-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            return DIM_WIDTH'($urandom_range(1, 3));
        end else if (roll == 7) begin
            return '0;
        end
        return DIM_WIDTH'($urandom_range(4, 15));
    endfunction

    // Raw rows_b value whose effective size equals (or differs from) cols_a
    function automatic logic [DIM_WIDTH-1:0] inner_dim(input logic [DIM_WIDTH-1:0] ca,
                                                       input bit match);
        logic [DIM_WIDTH-1:0] pick;
        pick = DIM_WIDTH'($urandom);
        while ((effective_dim(pick) == effective_dim(ca)) != match) begin
            pick = DIM_WIDTH'($urandom);
        end
        return pick;
    endfunction

    function automatic logic [15:0] random_element();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return 16'h8000;
        end else if (roll == 1) begin
            return 16'h7fff;
        end
        return 16'($urandom);
    endfunction

    // Store one accepted element; on the element that completes B, queue the run's results
    task automatic absorb_element(input logic signed [DATA_WIDTH-1:0] element);
        int unsigned   ra, ca, rb, cb, na, nb, pos;
        logic signed [ACC_WIDTH-1:0] acc;
        product_item_t entry;
        ra = effective_dim(dim_regs[REG_ROWS_A]);
        ca = effective_dim(dim_regs[REG_COLS_A]);
        rb = effective_dim(dim_regs[REG_ROWS_B]);
        cb = effective_dim(dim_regs[REG_COLS_B]);
        na = ra * ca;
        nb = rb * cb;
        pos = load_pos;
        if (pos < na) begin
            a_elems[pos] = element;
        end else if (pos - na < nb) begin
            b_elems[pos - na] = element;
        end
        if (pos + 1 < na + nb) begin
            load_pos = pos + 1;
        end else begin
            load_pos = 0;
            if (ca != rb) begin
                entry.product = '0;
                entry.status  = 1'b1;
                entry.last    = 1'b1;
                pending_products.push_back(entry);
            end else begin
                for (int unsigned r = 0; r < ra; r++) begin
                    for (int unsigned c = 0; c < cb; c++) begin
                        acc = '0;
                        for (int unsigned k = 0; k < ca; k++) begin
                            acc = acc + a_elems[r * ca + k] * b_elems[k * cb + c];
                        end
                        entry.product = acc;
                        entry.status  = 1'b0;
                        entry.last    = (r + 1 == ra) && (c + 1 == cb);
                        pending_products.push_back(entry);
                    end
                end
            end
        end
    endtask

    // Sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the item until taken
        end else if (src_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= src_gap - 1;
        end else if (outgoing_elements.size() != 0) begin
            s_axis_tdata  <= outgoing_elements.pop_front();
            s_axis_tvalid <= 1'b1;
            src_gap       <= draw_gap(src_mode);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Long receiver stall, started by the first result after the request
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_request && !hold_taken && m_axis_tvalid) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver
    always @(posedge aclk) begin : sink_ctrl
        int unsigned g;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end else if (hold_left != 0 || (hold_request && !hold_taken && m_axis_tvalid)) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            g = draw_gap(snk_mode);
            m_axis_tready <= (g == 0);
            snk_gap       <= (g == 0) ? 0 : g - 1;
        end else if (snk_gap != 0) begin
            m_axis_tready <= 1'b0;
            snk_gap       <= snk_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict on accepted elements, check accepted results
    always @(posedge aclk) begin : result_check
        product_item_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_element(s_axis_tdata);
                elements_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_products.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: data %h status %b last %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end else begin
                    want = pending_products.pop_front();
                    if (m_axis_tdata !== want.product || m_axis_tuser !== want.status ||
                        m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected data %h status %b last %b, got %h %b %b",
                                     want.product, want.status, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_element(input logic [15:0] value);
        outgoing_elements.push_back(value);
        elements_queued++;
    endtask

    // Wait until every element is taken and every result has come, then settle
    task automatic wait_idle();
        @(posedge aclk);
        while (elements_taken != elements_queued || pending_products.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [DIM_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        dim_regs[idx] = value;
    endtask

    task automatic set_dims(input logic [DIM_WIDTH-1:0] ra, ca, rb, cb);
        write_dim(REG_ROWS_A, ra);
        write_dim(REG_COLS_A, ca);
        write_dim(REG_ROWS_B, rb);
        write_dim(REG_COLS_B, cb);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0]          corner_a [8];
        logic [15:0]          corner_b [8];
        logic [DIM_WIDTH-1:0] ra, ca, rb, cb;
        int unsigned          run_len, runs, random_count;
        bit                   first_phase;

        corner_a = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                     16'h8000, 16'h0100, 16'h7fff, 16'h8000};
        corner_b = '{16'h8000, 16'h7fff, 16'h5a5a, 16'hffff,
                     16'h7fff, 16'h0100, 16'h8000, 16'h8000};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset sizes, 1x1 by 1x1: largest positive and negative squares
        queue_element(16'h7fff);
        queue_element(16'h7fff);
        queue_element(16'h8000);
        queue_element(16'h8000);
        wait_idle();

        // Zero acts as one, above eight acts as eight: 1x8 by 8x1
        set_dims(4'd0, 4'd15, 4'd9, 4'd0);
        foreach (corner_a[i]) queue_element(corner_a[i]);
        foreach (corner_b[i]) queue_element(corner_b[i]);
        wait_idle();

        // Inner sizes differ: single status item
        set_dims(4'd2, 4'd1, 4'd2, 4'd1);
        repeat (4) queue_element(16'($urandom));
        wait_idle();

        random_count = 0;
        first_phase  = 1'b1;
        while (random_count < RANDOM_ITEMS) begin
            if (first_phase) begin
                // small matching sizes so several runs line up behind the stall
                ra = DIM_WIDTH'($urandom_range(1, 3));
                ca = DIM_WIDTH'($urandom_range(1, 3));
                cb = DIM_WIDTH'($urandom_range(1, 3));
                rb = ca;
            end else begin
                ra = pick_dim();
                ca = pick_dim();
                cb = pick_dim();
                rb = inner_dim(ca, $urandom_range(0, 6) != 0);
            end
            set_dims(ra, ca, rb, cb);
            src_mode <= $urandom_range(0, 2);
            snk_mode <= $urandom_range(0, 2);
            run_len = effective_dim(ra) * effective_dim(ca) +
                      effective_dim(rb) * effective_dim(cb);
            runs = (run_len > 40) ? 1 : $urandom_range(1, 4);
            if (first_phase) begin
                // keep elements coming while the receiver stalls
                runs = 3;
                hold_request <= 1'b1;
                first_phase = 1'b0;
            end
            repeat (runs * run_len) queue_element(random_element());
            random_count += runs * run_len;
            wait_idle();
        end

        // Most results per run: 8x1 by 1x8
        src_mode <= 1;
        snk_mode <= 1;
        set_dims(4'd8, 4'd1, 4'd1, 4'd8);
        repeat (16) queue_element(random_element());
        wait_idle();
        repeat (32) @(posedge aclk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
